/* rtl/text_console_writer_top_assert.svh */
// Assertion macros used by the console writer controller.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define TCW_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcw: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw: sequence violated");

`endif

/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLS      = 80;
  localparam int ROWS      = 25;
  localparam int NCELLS    = COLS * ROWS;
  localparam int ADDR_W    = $clog2(NCELLS);
  localparam int COL_W     = $clog2(COLS);
  localparam int LAST_BASE = NCELLS - COLS;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_BLINK = 2'd2;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] PROMPT_A   = 8'h3E;
  localparam logic [7:0] PROMPT_B   = 8'h3A;
  localparam logic [7:0] ATTR_AUTO  = 8'hFF;
  localparam logic [7:0] BLINK_ATTR = 8'h22;

  localparam logic [0:0] CFG_TEXT_ATTR  = 1'b0;
  localparam logic [0:0] CFG_DIGIT_ATTR = 1'b1;

  typedef struct packed {
    logic [7:0] text_attr;
    logic [7:0] digit_attr;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [7:0]  attr_in;
    logic [10:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        did_scroll;
    logic [10:0] cursor_pos;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

/* rtl/tcw_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  char_code;
  logic [7:0]  attr_in;
  logic [10:0] cell_index;

  modport source (output valid, output op, output char_code, output attr_in,
                  output cell_index, input ready);
  modport sink (input valid, input op, input char_code, input attr_in,
                input cell_index, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic        did_scroll;
  logic [10:0] cursor_pos;

  modport source (output valid, output cell_char, output cell_attr, output did_scroll,
                  output cursor_pos, input ready);
  modport sink (input valid, input cell_char, input cell_attr, input did_scroll,
                input cursor_pos, output ready);
endinterface

`default_nettype wire

/* rtl/tcw_cell_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram (
  input  wire logic              clk_i,
  input  wire tcw_pkg::ram_req_t req_i,
  output logic [15:0]            rdata_o
);

  logic [15:0] mem [tcw_pkg::NCELLS];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/tcw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_top_assert.svh"

module tcw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcw_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tcw_pkg::item_t    item_i,
  output tcw_pkg::ram_req_t      ram_req_o,
  input  wire logic [15:0]       ram_rdata_i,
  input  wire logic              out_free_i,
  output logic                   res_valid_o,
  output tcw_pkg::result_t       res_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::COL_W;

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_BS_ATTR   = 4'd2;
  localparam logic [3:0] S_BS_ERASE  = 4'd3;
  localparam logic [3:0] S_BLINK     = 4'd4;
  localparam logic [3:0] S_READ      = 4'd5;
  localparam logic [3:0] S_SCR_COPY  = 4'd6;
  localparam logic [3:0] S_SCR_BLANK = 4'd7;
  localparam logic [3:0] S_NL_GT     = 4'd8;
  localparam logic [3:0] S_NL_COLON  = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  localparam logic [AW-1:0] LAST_CELL = AW'(tcw_pkg::NCELLS - 1);
  localparam logic [AW-1:0] LAST_BASE = AW'(tcw_pkg::LAST_BASE);
  localparam logic [AW-1:0] COLS_A    = AW'(tcw_pkg::COLS);
  localparam logic [CW-1:0] LAST_COL  = CW'(tcw_pkg::COLS - 1);

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] line_q, line_d;
  logic [AW-1:0] base_q, base_d;
  logic [7:0]    held_q, held_d;
  logic [7:0]    ch_q, ch_d;
  logic          scrolled_q, scrolled_d;
  logic [7:0]    rchar_q, rchar_d;
  logic [7:0]    rattr_q, rattr_d;

  logic [AW-1:0] row_base;
  logic [AW:0]   bs_limit;
  logic [7:0]    wr_attr;

  assign row_base = cursor_q - AW'(col_q);
  assign bs_limit = {1'b0, line_q} + (AW + 1)'(2);

  always_comb begin
    wr_attr = item_i.attr_in;
    if (item_i.attr_in == tcw_pkg::ATTR_AUTO) begin
      if (item_i.char_code inside {[tcw_pkg::CH_DIGIT_0:tcw_pkg::CH_DIGIT_9]}) begin
        wr_attr = cfg_i.digit_attr;
      end else begin
        wr_attr = cfg_i.text_attr;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cursor_d   = cursor_q;
    col_d      = col_q;
    line_d     = line_q;
    base_d     = base_q;
    held_d     = held_q;
    ch_d       = ch_q;
    scrolled_d = scrolled_q;
    rchar_d    = rchar_q;
    rattr_d    = rattr_q;
    ram_req_o  = '0;
    res_valid_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cnt_q;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          ch_d       = item_i.char_code;
          scrolled_d = 1'b0;
          rchar_d    = '0;
          rattr_d    = '0;
          state_d    = S_DONE;
          case (item_i.op)
            tcw_pkg::OP_WRITE: begin
              if (item_i.char_code == tcw_pkg::CH_LF) begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = cursor_q;
                ram_req_o.wdata = {held_q, tcw_pkg::CH_NUL};
                if (row_base == LAST_BASE) begin
                  scrolled_d = 1'b1;
                  base_d     = LAST_BASE;
                  cnt_d      = '0;
                  state_d    = S_SCR_COPY;
                end else begin
                  base_d  = row_base + COLS_A;
                  state_d = S_NL_GT;
                end
              end else if (item_i.char_code == tcw_pkg::CH_BS) begin
                if ({1'b0, cursor_q} > bs_limit) begin
                  ram_req_o.re    = 1'b1;
                  ram_req_o.raddr = cursor_q;
                  state_d         = S_BS_ATTR;
                end
              end else if (item_i.char_code != tcw_pkg::CH_NUL) begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = cursor_q;
                ram_req_o.wdata = {wr_attr, item_i.char_code};
                if (cursor_q == LAST_CELL) begin
                  scrolled_d = 1'b1;
                  cursor_d   = LAST_BASE;
                  col_d      = '0;
                  line_d     = (line_q >= COLS_A) ? line_q - COLS_A : '0;
                  cnt_d      = '0;
                  state_d    = S_SCR_COPY;
                end else begin
                  cursor_d = cursor_q + 1'b1;
                  col_d    = (col_q == LAST_COL) ? '0 : col_q + 1'b1;
                end
              end
            end
            tcw_pkg::OP_READ: begin
              if (32'(item_i.cell_index) < 32'(tcw_pkg::NCELLS)) begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = AW'(item_i.cell_index);
                state_d         = S_READ;
              end
            end
            tcw_pkg::OP_BLINK: begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = cursor_q;
              state_d         = S_BLINK;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_BS_ATTR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cursor_q;
        ram_req_o.wdata = {cfg_i.text_attr, ram_rdata_i[7:0]};
        cursor_d        = cursor_q - 1'b1;
        col_d           = (col_q == '0) ? LAST_COL : col_q - 1'b1;
        state_d         = S_BS_ERASE;
      end

      S_BS_ERASE: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cursor_q;
        ram_req_o.wdata = {cfg_i.text_attr, tcw_pkg::CH_NUL};
        state_d         = S_DONE;
      end

      S_BLINK: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cursor_q;
        if (ram_rdata_i[15:8] == tcw_pkg::BLINK_ATTR) begin
          ram_req_o.wdata = {held_q, ram_rdata_i[7:0]};
        end else begin
          held_d          = ram_rdata_i[15:8];
          ram_req_o.wdata = {tcw_pkg::BLINK_ATTR, ram_rdata_i[7:0]};
        end
        state_d = S_DONE;
      end

      S_READ: begin
        rchar_d = ram_rdata_i[7:0];
        rattr_d = ram_rdata_i[15:8];
        state_d = S_DONE;
      end

      S_SCR_COPY: begin
        // read one row ahead, write the cell fetched last cycle
        if (cnt_q != LAST_BASE) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = cnt_q + COLS_A;
        end
        if (cnt_q != '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = cnt_q - 1'b1;
          ram_req_o.wdata = ram_rdata_i;
        end
        if (cnt_q == LAST_BASE) begin
          state_d = S_SCR_BLANK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_SCR_BLANK: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cnt_q;
        ram_req_o.wdata = {cfg_i.text_attr, tcw_pkg::CH_NUL};
        if (cnt_q == LAST_CELL) begin
          state_d = (ch_q == tcw_pkg::CH_LF) ? S_NL_GT : S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_NL_GT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = base_q;
        ram_req_o.wdata = {cfg_i.digit_attr, tcw_pkg::PROMPT_A};
        state_d         = S_NL_COLON;
      end

      S_NL_COLON: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = base_q + 1'b1;
        ram_req_o.wdata = {cfg_i.digit_attr, tcw_pkg::PROMPT_B};
        cursor_d        = base_q + AW'(2);
        col_d           = CW'(2);
        line_d          = base_q;
        state_d         = S_DONE;
      end

      S_DONE: begin
        // hold until the output register can take the result
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cnt_q      <= '0;
      cursor_q   <= '0;
      col_q      <= '0;
      line_q     <= '0;
      held_q     <= '0;
      scrolled_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      cursor_q   <= cursor_d;
      col_q      <= col_d;
      line_q     <= line_d;
      held_q     <= held_d;
      scrolled_q <= scrolled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    ch_q    <= ch_d;
    rchar_q <= rchar_d;
    rattr_q <= rattr_d;
  end

  assign in_ready_o = (state_q == S_IDLE);

  assign res_o.cell_char  = rchar_q;
  assign res_o.cell_attr  = rattr_q;
  assign res_o.did_scroll = scrolled_q;
  assign res_o.cursor_pos = 11'(cursor_q);

  `TCW_ASSERT_ALWAYS(a_cursor_range, clk_i, rst_ni, 32'(cursor_q) < 32'(tcw_pkg::NCELLS))
  `TCW_ASSERT_ALWAYS(a_line_not_past_cursor, clk_i, rst_ni, line_q <= cursor_q)
  `TCW_ASSERT_ALWAYS(a_blank_only_when_scrolled, clk_i, rst_ni, (state_q != S_SCR_BLANK) || scrolled_q)
  `TCW_ASSERT_NEXT(a_result_returns_idle, clk_i, rst_ni, res_valid_o, state_q == S_IDLE)

endmodule

`default_nettype wire

/* rtl/text_console_writer_top.sv */
// Read and blink fetch the cell before the result; an erasing backspace restores the text
// attribute, then erases the cell before it; a write that scrolls copies the rows up, then blanks the bottom row.
// One item at a time: a new item is taken only in idle, after the last result went to the
// output register; the single write port of the cell memory paces the scroll and the prompt writes.
// Reset: cursor, line start and saved attribute go to zero, the text and digit attributes
// to 2 and 4; the cell memory is then cleared, one cell a cycle, with input held off.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tcw_in_if.sink          in_i,
  tcw_out_if.source       out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  tcw_pkg::cfg_t     cfg_q;
  tcw_pkg::item_t    item;
  tcw_pkg::ram_req_t ram_req;
  tcw_pkg::result_t  res;
  tcw_pkg::result_t  out_q;
  logic [15:0]       ram_rdata;
  logic              res_valid;
  logic              out_valid_q;
  logic              out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_attr  <= 8'd2;
      cfg_q.digit_attr <= 8'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcw_pkg::CFG_TEXT_ATTR:  cfg_q.text_attr  <= cfg_data_i;
        tcw_pkg::CFG_DIGIT_ATTR: cfg_q.digit_attr <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign item.op         = in_i.op;
  assign item.char_code  = in_i.char_code;
  assign item.attr_in    = in_i.attr_in;
  assign item.cell_index = in_i.cell_index;

  tcw_cell_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .item_i      (item),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cell_char  = out_q.cell_char;
  assign out_o.cell_attr  = out_q.cell_attr;
  assign out_o.did_scroll = out_q.did_scroll;
  assign out_o.cursor_pos = out_q.cursor_pos;

endmodule

`default_nettype wire

/* test/screen_checker.sv */
`timescale 1ns / 1ps

module screen_checker
  import tcw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tcw_in_if               in_mon,
  tcw_out_if              out_mon,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  output int              error_count_o,
  output int              pending_o
);

  localparam logic [7:0] TEXT_ATTR_RESET  = 8'd2;
  localparam logic [7:0] DIGIT_ATTR_RESET = 8'd4;
  localparam int         REPORT_LIMIT     = 10;

  // Shadow copy of the console: cells are {attr, char}
  logic [15:0] screen [NCELLS];
  int          cursor;
  int          line_start;
  logic [7:0]  held_attr;
  logic [7:0]  text_attr;
  logic [7:0]  digit_attr;
  int          errors;
  result_t     expected_replies [$];

  task automatic scroll_screen();
    for (int j = 0; j < LAST_BASE; j++) begin
      screen[j] = screen[j + COLS];
    end
    for (int j = LAST_BASE; j < NCELLS; j++) begin
      screen[j] = {text_attr, CH_NUL};
    end
  endtask

  task automatic apply_console_item(input item_t cmd, output result_t res);
    int         next_base;
    logic [7:0] glyph_attr;
    logic [7:0] cur_attr;
    res = '0;
    case (cmd.op)
      OP_WRITE: begin
        if (cmd.char_code == CH_LF) begin
          screen[cursor] = {held_attr, CH_NUL};
          next_base = (cursor / COLS + 1) * COLS;
          if (next_base >= NCELLS) begin
            scroll_screen();
            next_base = LAST_BASE;
            res.did_scroll = 1'b1;
          end
          // prompt goes in after the scroll
          screen[next_base]     = {digit_attr, PROMPT_A};
          screen[next_base + 1] = {digit_attr, PROMPT_B};
          cursor     = next_base + 2;
          line_start = next_base;
        end else if (cmd.char_code == CH_BS) begin
          // never erase into the prompt
          if (cursor > line_start + 2) begin
            screen[cursor][15:8] = text_attr;
            cursor--;
            screen[cursor] = {text_attr, CH_NUL};
          end
        end else if (cmd.char_code != CH_NUL) begin
          glyph_attr = cmd.attr_in;
          if (cmd.attr_in == ATTR_AUTO) begin
            glyph_attr = (cmd.char_code >= CH_DIGIT_0 && cmd.char_code <= CH_DIGIT_9) ?
                         digit_attr : text_attr;
          end
          screen[cursor] = {glyph_attr, cmd.char_code};
          cursor++;
          if (cursor >= NCELLS) begin
            scroll_screen();
            cursor     = LAST_BASE;
            line_start = (line_start >= COLS) ? line_start - COLS : 0;
            res.did_scroll = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (cmd.cell_index < NCELLS) begin
          res.cell_char = screen[cmd.cell_index][7:0];
          res.cell_attr = screen[cmd.cell_index][15:8];
        end
      end
      OP_BLINK: begin
        cur_attr = screen[cursor][15:8];
        if (cur_attr == BLINK_ATTR) begin
          screen[cursor][15:8] = held_attr;
        end else begin
          held_attr = cur_attr;
          screen[cursor][15:8] = BLINK_ATTR;
        end
      end
      default: ;
    endcase
    res.cursor_pos = cursor[10:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   cmd;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int j = 0; j < NCELLS; j++) begin
        screen[j] = '0;
      end
      cursor     = 0;
      line_start = 0;
      held_attr  = '0;
      text_attr  = TEXT_ATTR_RESET;
      digit_attr = DIGIT_ATTR_RESET;
      errors     = 0;
      expected_replies.delete();
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TEXT_ATTR) begin
          text_attr = cfg_data_i;
        end else if (cfg_idx_i == CFG_DIGIT_ATTR) begin
          digit_attr = cfg_data_i;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        cmd.op         = in_mon.op;
        cmd.char_code  = in_mon.char_code;
        cmd.attr_in    = in_mon.attr_in;
        cmd.cell_index = in_mon.cell_index;
        apply_console_item(cmd, want);
        expected_replies.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.cell_char  = out_mon.cell_char;
        got.cell_attr  = out_mon.cell_attr;
        got.did_scroll = out_mon.did_scroll;
        got.cursor_pos = out_mon.cursor_pos;
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: unexpected reply char %02h attr %02h scroll %0b cursor %0d",
                     $realtime, got.cell_char, got.cell_attr, got.did_scroll, got.cursor_pos);
          end
        end else begin
          want = expected_replies.pop_front();
          if (got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
              got.did_scroll !== want.did_scroll || got.cursor_pos !== want.cursor_pos) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: reply mismatch: expected char %02h attr %02h scroll %0b cursor %0d",
                       $realtime, want.cell_char, want.cell_attr, want.did_scroll,
                       want.cursor_pos);
              $display("%0t:                 actual char %02h attr %02h scroll %0b cursor %0d",
                       $realtime, got.cell_char, got.cell_attr, got.did_scroll, got.cursor_pos);
            end
          end
        end
      end
      error_count_o <= errors;
      pending_o     <= expected_replies.size();
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int         CYCLE_LIMIT = 30_000_000;
  localparam int         MAX_GAP     = 40;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         INDEX_TOP   = 2047;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [0:0] cfg_idx;
  logic [7:0] cfg_data;
  int         src_idle_pct   = 0;
  int         sink_stall_pct = 0;
  int         error_count;
  int         pending_count;
  longint     cycle_count;

  tcw_in_if  in_bus ();
  tcw_out_if out_bus ();

  text_console_writer_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  screen_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .error_count_o (error_count),
    .pending_o     (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic item_t cmd_of(logic [1:0] op, logic [7:0] ch, logic [7:0] at,
                                   logic [10:0] idx);
    item_t it;
    it.op         = op;
    it.char_code  = ch;
    it.attr_in    = at;
    it.cell_index = idx;
    return it;
  endfunction

  // non-NUL glyph other than newline and backspace, digits weighted up so the auto attribute picks both ways
  function automatic logic [7:0] pick_glyph();
    logic [7:0] ch;
    if ($urandom_range(0, 99) < 35) begin
      ch = CH_DIGIT_0 + 8'($urandom_range(0, 9));
    end else begin
      ch = 8'($urandom_range(1, 255));
      if (ch == CH_LF || ch == CH_BS) ch = PROMPT_A;
    end
    return ch;
  endfunction

  // half the time near the bottom rows where the text lands, else anywhere; sometimes past the screen
  function automatic logic [10:0] read_target();
    if ($urandom_range(0, 1)) return 11'($urandom_range(LAST_BASE - 2 * COLS, INDEX_TOP));
    return 11'($urandom_range(0, INDEX_TOP));
  endfunction

  function automatic item_t random_cmd(bit long_text);
    item_t it;
    int    roll;
    it.op         = OP_WRITE;
    it.char_code  = 8'($urandom_range(0, 255));
    it.attr_in    = 8'($urandom_range(0, 255));
    it.cell_index = 11'($urandom_range(0, INDEX_TOP));
    roll = $urandom_range(0, 99);
    if (long_text) begin
      if (roll < 88) begin
        it.char_code = pick_glyph();
        if ($urandom_range(0, 1)) it.attr_in = ATTR_AUTO;
      end else if (roll < 93) begin
        it.char_code = CH_BS;
      end else if (roll < 97) begin
        it.op = OP_READ;
        it.cell_index = read_target();
      end else begin
        it.op = OP_BLINK;
      end
    end else if (roll < 55) begin
      it.char_code = pick_glyph();
      if ($urandom_range(0, 1)) it.attr_in = ATTR_AUTO;
    end else if (roll < 63) begin
      it.char_code = CH_LF;
    end else if (roll < 71) begin
      it.char_code = CH_BS;
    end else if (roll < 83) begin
      it.op = OP_READ;
      it.cell_index = read_target();
    end else if (roll < 90) begin
      it.op = OP_BLINK;
    end else if (roll < 93) begin
      it.char_code = CH_NUL;
    end else if (roll < 95) begin
      it.op = OP_UNUSED;
    end else begin
      it.op = 2'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // call right after a rising edge; returns at the edge of the transfer
  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= it.op;
    in_bus.char_code  <= it.char_code;
    in_bus.attr_in    <= it.attr_in;
    in_bus.cell_index <= it.cell_index;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_attrs(input logic [7:0] text_val, input logic [7:0] digit_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TEXT_ATTR;
    cfg_data <= text_val;
    @(posedge clk_i);
    cfg_idx  <= CFG_DIGIT_ATTR;
    cfg_data <= digit_val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int count, input bit long_text);
    for (int k = 0; k < count; k++) begin
      send_item(random_cmd(long_text));
    end
  endtask

  initial begin
    item_t opening [$];
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_TEXT_ATTR;
    cfg_data          <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.op         <= OP_WRITE;
    in_bus.char_code  <= CH_NUL;
    in_bus.attr_in    <= '0;
    in_bus.cell_index <= '0;

    opening.push_back(cmd_of(OP_READ,  CH_NUL, 8'h00, 11'd0));
    opening.push_back(cmd_of(OP_READ,  CH_NUL, 8'h00, 11'(NCELLS - 1)));
    opening.push_back(cmd_of(OP_READ,  CH_NUL, 8'h00, 11'(INDEX_TOP)));
    opening.push_back(cmd_of(OP_WRITE, 8'h41,  ATTR_AUTO, 11'd0));
    opening.push_back(cmd_of(OP_WRITE, CH_DIGIT_0, ATTR_AUTO, 11'd0));
    opening.push_back(cmd_of(OP_WRITE, CH_DIGIT_9, ATTR_AUTO, 11'd0));
    opening.push_back(cmd_of(OP_WRITE, CH_DIGIT_0 - 8'd1, ATTR_AUTO, 11'd0));
    opening.push_back(cmd_of(OP_WRITE, CH_DIGIT_9 + 8'd1, ATTR_AUTO, 11'd0));
    opening.push_back(cmd_of(OP_WRITE, 8'hFF,  8'h00, 11'(INDEX_TOP)));
    opening.push_back(cmd_of(OP_WRITE, 8'h01,  8'hFE, 11'd0));
    opening.push_back(cmd_of(OP_WRITE, CH_NUL, ATTR_AUTO, 11'd0));
    // blink on, then off again
    opening.push_back(cmd_of(OP_BLINK, CH_NUL, 8'h00, 11'd0));
    opening.push_back(cmd_of(OP_BLINK, CH_NUL, 8'h00, 11'd0));
    opening.push_back(cmd_of(OP_WRITE, CH_BS,  8'h00, 11'd0));
    opening.push_back(cmd_of(OP_BLINK, CH_NUL, 8'h00, 11'd0));
    opening.push_back(cmd_of(OP_WRITE, CH_LF,  8'hFF, 11'(INDEX_TOP)));
    // backspace must stop at the prompt
    opening.push_back(cmd_of(OP_WRITE, CH_BS,  8'h00, 11'd0));
    opening.push_back(cmd_of(OP_WRITE, 8'h37,  BLINK_ATTR, 11'd0));
    opening.push_back(cmd_of(OP_UNUSED, 8'hFF, 8'hFF, 11'(INDEX_TOP)));
    opening.push_back(cmd_of(OP_READ,  CH_NUL, 8'h00, 11'd0));
    opening.push_back(cmd_of(OP_READ,  CH_NUL, 8'h00, 11'(COLS)));
    opening.push_back(cmd_of(OP_READ,  CH_NUL, 8'h00, 11'd7));
    opening.push_back(cmd_of(OP_READ,  CH_NUL, 8'h00, 11'(NCELLS)));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[k]) send_item(opening[k]);
    wait_drained();

    // no idling; newlines down past the bottom row, then long text that overflows it
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    program_attrs(8'h00, 8'hFF);
    for (int k = 0; k < ROWS; k++) begin
      send_item(cmd_of(OP_WRITE, CH_LF, ATTR_AUTO, 11'd0));
    end
    run_random(250, 1'b1);
    wait_drained();

    src_idle_pct   = 75;
    sink_stall_pct = 0;
    program_attrs(8'hFF, 8'h00);
    run_random(250, 1'b0);
    wait_drained();

    src_idle_pct   = 0;
    sink_stall_pct = 75;
    program_attrs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random(250, 1'b0);
    wait_drained();

    src_idle_pct   = 22;
    sink_stall_pct = 22;
    program_attrs(BLINK_ATTR, BLINK_ATTR);
    run_random(225, 1'b0);
    // hold the sender until every reply is back
    wait_drained();
    run_random(225, 1'b0);
    wait_drained();
    repeat (NCELLS + 16) @(posedge clk_i);

    if (error_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
